/* hw/rtl/fpd_pkg.sv */
`timescale 1ns / 1ps

package fpd_pkg;

   // Configuration port
   localparam int CSR_DATA_W = 9;
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLUME_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLUME_HEIGHT = 1'd1;

   // Field widths
   localparam int FACTOR_W = 17;
   localparam int FLOW_W   = 32;

   // Product of a flow and the sum of two factors, and the widened sum range
   localparam int PROD_W      = FLOW_W + FACTOR_W + 2;
   localparam int SUM_W       = FLOW_W + 3;
   localparam int ROUND_SHIFT = FACTOR_W;

   // Stream widths
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 128;

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;

   localparam logic signed [FLOW_W-1:0] FLOW_MAX = {1'b0, {(FLOW_W-1){1'b1}}};
   localparam logic signed [FLOW_W-1:0] FLOW_MIN = {1'b1, {(FLOW_W-1){1'b0}}};

   // One voxel as it travels through the block
   typedef struct packed {
      logic [FACTOR_W-1:0]      allowed;
      logic signed [FLOW_W-1:0] flow_x;
      logic signed [FLOW_W-1:0] flow_y;
      logic signed [FLOW_W-1:0] flow_z;
   } fpd_voxel_type;

   // Which backward neighbors lie inside the volume
   typedef struct packed {
      logic has_x;
      logic has_y;
      logic has_z;
   } fpd_nbr_type;

   // Saturate a widened sum to a signed 32-bit flow.
   function automatic logic signed [FLOW_W-1:0] fpd_sat(input logic signed [SUM_W-1:0] v);
      logic signed [FLOW_W-1:0] r;
      if ((v[SUM_W-1:FLOW_W-1] == '0) || (v[SUM_W-1:FLOW_W-1] == '1)) begin
         r = v[FLOW_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = FLOW_MIN;
      end else begin
         r = FLOW_MAX;
      end
      return r;
   endfunction

   // Divide a product by 2^17, rounding halves upward, then saturate.
   function automatic logic signed [FLOW_W-1:0] fpd_scale_round(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0]             biased;
      logic signed [PROD_W-ROUND_SHIFT:0] q;
      biased = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (ROUND_SHIFT - 1));
      q      = biased[PROD_W:ROUND_SHIFT];
      return fpd_sat(q);
   endfunction

endpackage

/* hw/rtl/flow_projection_divergence_3d_top.sv */
`timescale 1ns / 1ps

// Flow projection with backward divergence over a 3D volume.
// req_* takes one voxel per item in raster order (column, then row, then
// plane); req_tuser marks the first voxel of a volume and restarts the
// position. rsp_* returns one item per voxel: the three projected flows and
// their divergence. csr_* sets the volume width and height; write it only
// while no item is in flight.
// An item accepted on req_* passes through the queue, then the store read,
// multiply and rounding stages, after which the divergence sum lands in the
// output register and the item leaves on rsp_*.
// One item is accepted and one returned every cycle while rsp_tready is high.
// A four-entry queue sits between the position front end and the compute
// pipeline. When rsp_tready is low the compute pipeline holds, the queue
// fills, and req_tready drops once it is full.
// Reset restores height to 256, width to 256 or MAX_WIDTH if smaller, and
// the position to the start of a volume. The row and plane stores are not
// cleared; a volume is expected to start with the first-voxel mark.
module flow_projection_divergence_3d_top import fpd_pkg::*; #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_PLANE = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input voxels
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // allowed, flow_x_in, flow_y_in, flow_z_in
   input  logic                  req_tuser,  // first_voxel
   // Results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // flow_x_out, flow_y_out, flow_z_out, divergence
   // Configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WAW         = $clog2(MAX_WIDTH);
   localparam int WW          = $clog2(MAX_WIDTH + 1);
   localparam int PAW         = $clog2(MAX_PLANE);
   localparam int CW          = (WW > CSR_DATA_W) ? WW : CSR_DATA_W;
   localparam int RESET_WIDTH = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int QW          = $bits(fpd_voxel_type) + $bits(fpd_nbr_type) + WAW + PAW;

   logic [WW-1:0]         width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [CW-1:0]         csr_wide;
   logic [WW-1:0]         width_clamp;
   logic [CSR_DATA_W-1:0] height_clamp;

   logic                  f_push;
   fpd_voxel_type         f_voxel;
   logic [WAW-1:0]        f_col;
   logic [PAW-1:0]        f_addr;
   fpd_nbr_type           f_nbr;
   logic                  q_ready;
   logic                  q_valid;
   logic                  q_pop;
   logic [QW-1:0]         q_rdata;
   fpd_voxel_type         h_voxel;
   logic [WAW-1:0]        h_col;
   logic [PAW-1:0]        h_addr;
   fpd_nbr_type           h_nbr;

   // Register writes; values are clamped to the supported range on entry.
   assign csr_wide     = CW'(csr_wdata);
   assign width_clamp  = (csr_wdata == '0) ? WW'(1) :
                         (csr_wide > CW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(csr_wide);
   assign height_clamp = (csr_wdata == '0) ? CSR_DATA_W'(1) : csr_wdata;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_VOLUME_WIDTH:  width_in  = width_clamp;
            CSR_VOLUME_HEIGHT: height_in = height_clamp;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RESET_WIDTH);
         height_ff <= CSR_DATA_W'(256);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   fpd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_PLANE(MAX_PLANE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .width      (width_ff),
      .height     (height_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (f_push),
      .q_voxel    (f_voxel),
      .q_col      (f_col),
      .q_addr     (f_addr),
      .q_nbr      (f_nbr)
   );

   fpd_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (f_push),
      .in_data   ({f_addr, f_col, f_nbr, f_voxel}),
      .in_ready  (q_ready),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_data  (q_rdata)
   );

   assign {h_addr, h_col, h_nbr, h_voxel} = q_rdata;

   fpd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_PLANE(MAX_PLANE)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_voxel    (h_voxel),
      .q_col      (h_col),
      .q_addr     (h_addr),
      .q_nbr      (h_nbr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hw/rtl/fpd_ram.sv */
`timescale 1ns / 1ps

module fpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port; a read of the address being
   // written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/fpd_front.sv */
`timescale 1ns / 1ps

module fpd_front import fpd_pkg::*; #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_PLANE = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   width,
   input  logic [CSR_DATA_W-1:0]            height,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_DATA_W-1:0]            req_tdata,
   input  logic                             req_tuser,
   input  logic                             q_ready,
   output logic                             q_push,
   output fpd_voxel_type                    q_voxel,
   output logic [$clog2(MAX_WIDTH)-1:0]     q_col,
   output logic [$clog2(MAX_PLANE)-1:0]     q_addr,
   output fpd_nbr_type                      q_nbr
);

   localparam int WAW = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int PAW = $clog2(MAX_PLANE);
   localparam int XW  = PAW + WW + 2;
   localparam int RCW = (PAW + 1 > CSR_DATA_W) ? PAW + 1 : CSR_DATA_W;

   logic [WAW-1:0] col_ff, col_in;
   logic [PAW-1:0] row_ff, row_in;
   logic           first_plane_ff, first_plane_in;

   logic           accept;
   logic [WAW-1:0] col_cur;
   logic [PAW-1:0] row_cur;
   logic           first_plane_cur;
   logic [XW-1:0]  row_base;
   logic [XW-1:0]  addr_sum;
   logic [WW-1:0]  col_next;
   logic [RCW-1:0] row_next;
   logic           col_wrap;
   logic           row_wrap;

   assign accept     = req_tvalid && q_ready;
   assign req_tready = q_ready;

   // The first-voxel mark restarts the position before the voxel is used.
   assign col_cur         = req_tuser ? '0 : col_ff;
   assign row_cur         = req_tuser ? '0 : row_ff;
   assign first_plane_cur = req_tuser ? 1'b1 : first_plane_ff;

   // Plane address is row * width + column, kept within the plane store.
   assign row_base = XW'(row_cur) * XW'(width);
   assign addr_sum = row_base + XW'(col_cur);

   // A row ends at the width; a plane ends at the height, or where one more
   // row would no longer fit in the plane store.
   assign col_next = WW'(col_cur) + WW'(1);
   assign row_next = RCW'(row_cur) + RCW'(1);
   assign col_wrap = col_next >= width;
   assign row_wrap = (row_next >= RCW'(height)) ||
                     ((row_base + (XW'(width) << 1)) > XW'(MAX_PLANE));

   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      first_plane_in = first_plane_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               row_in         = '0;
               first_plane_in = 1'b0;
            end else begin
               row_in         = row_next[PAW-1:0];
               first_plane_in = first_plane_cur;
            end
         end else begin
            col_in         = col_next[WAW-1:0];
            row_in         = row_cur;
            first_plane_in = first_plane_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         first_plane_ff <= 1'b1;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         first_plane_ff <= first_plane_in;
      end
   end

   // Classified item toward the queue
   assign q_push         = accept;
   assign q_voxel.allowed = req_tdata[FACTOR_W-1:0];
   assign q_voxel.flow_x  = req_tdata[FACTOR_W+FLOW_W-1:FACTOR_W];
   assign q_voxel.flow_y  = req_tdata[FACTOR_W+2*FLOW_W-1:FACTOR_W+FLOW_W];
   assign q_voxel.flow_z  = req_tdata[FACTOR_W+3*FLOW_W-1:FACTOR_W+2*FLOW_W];
   assign q_col          = col_cur;
   assign q_addr         = addr_sum[PAW-1:0];
   assign q_nbr.has_x    = col_cur != '0;
   assign q_nbr.has_y    = row_cur != '0;
   assign q_nbr.has_z    = !first_plane_cur;

endmodule

/* hw/rtl/fpd_queue.sv */
`timescale 1ns / 1ps

module fpd_queue import fpd_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   input  logic [WIDTH-1:0] in_data,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [WIDTH-1:0] out_data
);

   localparam int QAW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;

   assign in_ready  = count_ff != (QAW+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = in_push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = out_pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QAW+1)'(in_push) - (QAW+1)'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage
   always_ff @(posedge clock) begin
      if (in_push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* hw/rtl/fpd_back.sv */
`timescale 1ns / 1ps

module fpd_back import fpd_pkg::*; #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_PLANE = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  fpd_voxel_type                q_voxel,
   input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
   input  logic [$clog2(MAX_PLANE)-1:0] q_addr,
   input  fpd_nbr_type                  q_nbr,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int WAW = $clog2(MAX_WIDTH);
   localparam int PAW = $clog2(MAX_PLANE);

   logic adv;
   logic pop;

   // Stage 1: voxel and factors of its neighbors
   logic                s1_valid_ff;
   fpd_voxel_type       s1_voxel_ff;
   logic [WAW-1:0]      s1_col_ff;
   logic [PAW-1:0]      s1_addr_ff;
   fpd_nbr_type         s1_nbr_ff;
   logic [FACTOR_W-1:0] s1_prev_allowed_ff;
   logic [FACTOR_W-1:0] prev_allowed_ff;
   logic [FACTOR_W-1:0] arow_rd;
   logic [FACTOR_W-1:0] aplane_rd;

   // Stage 2: products
   logic                     s2_valid_ff;
   logic [WAW-1:0]           s2_col_ff;
   logic [PAW-1:0]           s2_addr_ff;
   fpd_nbr_type              s2_nbr_ff;
   logic signed [PROD_W-1:0] s2_px_ff, s2_py_ff, s2_pz_ff;
   logic [FACTOR_W:0]        sum_x_in, sum_y_in, sum_z_in;
   logic signed [PROD_W-1:0] px_in, py_in, pz_in;

   // Stage 3: new flows and the old flows of the neighbors
   logic                     s3_valid_ff;
   logic [WAW-1:0]           s3_col_ff;
   logic [PAW-1:0]           s3_addr_ff;
   fpd_nbr_type              s3_nbr_ff;
   logic signed [FLOW_W-1:0] s3_nx_ff, s3_ny_ff, s3_nz_ff;
   logic signed [FLOW_W-1:0] nx_in, ny_in, nz_in;
   logic                     s3_fwd_y_ff, s3_fwd_z_ff;
   logic signed [FLOW_W-1:0] s3_fwd_yv_ff, s3_fwd_zv_ff;
   logic                     fwd_y_in, fwd_z_in;
   logic signed [FLOW_W-1:0] prev_nx_ff;
   logic [FLOW_W-1:0]        yrow_rd;
   logic [FLOW_W-1:0]        zplane_rd;

   // Output register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic signed [FLOW_W-1:0] old_y, old_z;
   logic signed [SUM_W-1:0]  div_sum;
   logic signed [FLOW_W-1:0] div_in;

   // The whole pipeline moves whenever the output register can take an item.
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign pop   = adv && q_valid;
   assign q_pop = pop;

   // Factor stores: written as the voxel enters, read before the write.
   fpd_ram #(.WIDTH(FACTOR_W), .DEPTH(MAX_WIDTH)) u_allowed_row (
      .clock (clock),
      .we    (pop),
      .waddr (q_col),
      .wdata (q_voxel.allowed),
      .re    (adv),
      .raddr (q_col),
      .rdata (arow_rd)
   );

   fpd_ram #(.WIDTH(FACTOR_W), .DEPTH(MAX_PLANE)) u_allowed_plane (
      .clock (clock),
      .we    (pop),
      .waddr (q_addr),
      .wdata (q_voxel.allowed),
      .re    (adv),
      .raddr (q_addr),
      .rdata (aplane_rd)
   );

   // New-flow stores: read as an item enters stage 3, written as it leaves.
   fpd_ram #(.WIDTH(FLOW_W), .DEPTH(MAX_WIDTH)) u_flow_y_row (
      .clock (clock),
      .we    (adv && s3_valid_ff),
      .waddr (s3_col_ff),
      .wdata (s3_ny_ff),
      .re    (adv),
      .raddr (s2_col_ff),
      .rdata (yrow_rd)
   );

   fpd_ram #(.WIDTH(FLOW_W), .DEPTH(MAX_PLANE)) u_flow_z_plane (
      .clock (clock),
      .we    (adv && s3_valid_ff),
      .waddr (s3_addr_ff),
      .wdata (s3_nz_ff),
      .re    (adv),
      .raddr (s2_addr_ff),
      .rdata (zplane_rd)
   );

   // Stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         prev_allowed_ff <= '0;
      end else begin
         if (adv) begin
            s1_valid_ff <= pop;
         end
         if (pop) begin
            prev_allowed_ff <= q_voxel.allowed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_voxel_ff        <= q_voxel;
         s1_col_ff          <= q_col;
         s1_addr_ff         <= q_addr;
         s1_nbr_ff          <= q_nbr;
         s1_prev_allowed_ff <= prev_allowed_ff;
      end
   end

   // Stage 1 to 2: each flow times the sum of its two factors
   always_comb begin
      sum_x_in = {1'b0, s1_voxel_ff.allowed} + {1'b0, s1_prev_allowed_ff};
      sum_y_in = {1'b0, s1_voxel_ff.allowed} + {1'b0, arow_rd};
      sum_z_in = {1'b0, s1_voxel_ff.allowed} + {1'b0, aplane_rd};
      px_in    = PROD_W'(s1_voxel_ff.flow_x) * PROD_W'($signed({1'b0, sum_x_in}));
      py_in    = PROD_W'(s1_voxel_ff.flow_y) * PROD_W'($signed({1'b0, sum_y_in}));
      pz_in    = PROD_W'(s1_voxel_ff.flow_z) * PROD_W'($signed({1'b0, sum_z_in}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_col_ff  <= s1_col_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_nbr_ff  <= s1_nbr_ff;
         s2_px_ff   <= px_in;
         s2_py_ff   <= py_in;
         s2_pz_ff   <= pz_in;
      end
   end

   // Stage 2 to 3: round and saturate; zero at a volume border.
   // The item leaving stage 3 writes its flows in the same cycle, so a
   // matching address takes its values directly.
   always_comb begin
      nx_in    = s2_nbr_ff.has_x ? fpd_scale_round(s2_px_ff) : '0;
      ny_in    = s2_nbr_ff.has_y ? fpd_scale_round(s2_py_ff) : '0;
      nz_in    = s2_nbr_ff.has_z ? fpd_scale_round(s2_pz_ff) : '0;
      fwd_y_in = s3_valid_ff && (s3_col_ff == s2_col_ff);
      fwd_z_in = s3_valid_ff && (s3_addr_ff == s2_addr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         prev_nx_ff  <= '0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff) begin
            prev_nx_ff <= s3_nx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_col_ff    <= s2_col_ff;
         s3_addr_ff   <= s2_addr_ff;
         s3_nbr_ff    <= s2_nbr_ff;
         s3_nx_ff     <= nx_in;
         s3_ny_ff     <= ny_in;
         s3_nz_ff     <= nz_in;
         s3_fwd_y_ff  <= fwd_y_in;
         s3_fwd_z_ff  <= fwd_z_in;
         s3_fwd_yv_ff <= s3_ny_ff;
         s3_fwd_zv_ff <= s3_nz_ff;
      end
   end

   // Stage 3 to output: backward-difference divergence, saturated
   always_comb begin
      old_y   = s3_fwd_y_ff ? s3_fwd_yv_ff : $signed(yrow_rd);
      old_z   = s3_fwd_z_ff ? s3_fwd_zv_ff : $signed(zplane_rd);
      div_sum = SUM_W'(s3_nx_ff) + SUM_W'(s3_ny_ff) + SUM_W'(s3_nz_ff)
              - (s3_nbr_ff.has_x ? SUM_W'(prev_nx_ff) : SUM_W'(0))
              - (s3_nbr_ff.has_y ? SUM_W'(old_y) : SUM_W'(0))
              - (s3_nbr_ff.has_z ? SUM_W'(old_z) : SUM_W'(0));
      div_in  = fpd_sat(div_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {div_in, s3_nz_ff, s3_ny_ff, s3_nx_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
